### rtl/des_pkg.sv
// Shared types and constants of the double exponential smoother.
// Holds the item structs, the datapath command struct and the register map.
// No dependencies.
`default_nettype none

package des_pkg;

  localparam int unsigned DEF_CHANNELS = 3;
  localparam int unsigned MAX_CHANNELS = 3;
  localparam int unsigned CH_IDX_W     = 2;
  localparam int unsigned SAMPLE_W     = 32;
  localparam int unsigned GAIN_W       = 17;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 2'd1;

  localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'd65536;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd32768;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_x;
    logic signed [SAMPLE_W-1:0] sample_y;
    logic signed [SAMPLE_W-1:0] sample_z;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smoothed_x;
    logic signed [SAMPLE_W-1:0] smoothed_y;
    logic signed [SAMPLE_W-1:0] smoothed_z;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_MUL_S,
    OP_ACC_S,
    OP_MUL_B,
    OP_ACC_B
  } op_e;

  typedef struct packed {
    logic                load_in;
    logic                prime;
    op_e                 op;
    logic [CH_IDX_W-1:0] ch;
    logic                load_out;
  } dp_cmd_t;

endpackage

`default_nettype wire

### rtl/des_in_if.sv
// Input channel of the smoother: valid, ready and one sample item.
// Depends on des_pkg.
`default_nettype none

interface des_in_if;
  logic              valid;
  logic              ready;
  des_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/des_out_if.sv
// Output channel of the smoother: valid, ready and one smoothed item.
// Depends on des_pkg.
`default_nettype none

interface des_out_if;
  logic               valid;
  logic               ready;
  des_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/des_datapath.sv
// Datapath of the smoother: sample, level and trend registers, gain registers,
// one shared multiplier and the round-and-saturate accumulator. Depends on des_pkg.
`default_nettype none

module des_datapath #(
  parameter int unsigned CHANNELS = des_pkg::DEF_CHANNELS
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire des_pkg::dp_cmd_t                   cmd_i,
  input  wire des_pkg::in_item_t                  in_data_i,
  output des_pkg::out_item_t                      out_data_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [des_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [des_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import des_pkg::*;

  localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned DIFF_W = SAMPLE_W + 2;
  localparam int unsigned ACC_W  = DIFF_W + GAIN_W + 1;

  logic [GAIN_W-1:0]          alpha_q;
  logic [GAIN_W-1:0]          gamma_q;
  logic signed [SAMPLE_W-1:0] smp_q   [CHANNELS];
  logic signed [SAMPLE_W-1:0] level_q [CHANNELS];
  logic signed [SAMPLE_W-1:0] trend_q [CHANNELS];
  logic signed [SAMPLE_W-1:0] s_q     [CHANNELS];
  logic signed [ACC_W-1:0]    prod_q;
  out_item_t                  out_q;

  logic signed [SAMPLE_W-1:0] smp_in  [MAX_CHANNELS];
  logic signed [SAMPLE_W-1:0] res_all [MAX_CHANNELS];

  logic [CH_W-1:0]            ch;
  logic signed [SAMPLE_W-1:0] x_cur;
  logic signed [SAMPLE_W-1:0] lv_cur;
  logic signed [SAMPLE_W-1:0] tr_cur;
  logic signed [SAMPLE_W-1:0] s_cur;
  logic signed [DIFF_W-1:0]   lt_sum;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [DIFF_W-1:0]   base;
  logic [GAIN_W-1:0]          gain_raw;
  logic signed [GAIN_W:0]     gain_s;
  logic signed [ACC_W-1:0]    mul_res;
  logic signed [ACC_W-1:0]    acc;
  logic signed [SAMPLE_W-1:0] sat_res;

  function automatic logic signed [DIFF_W-1:0] sext(input logic signed [SAMPLE_W-1:0] v);
    sext = {{(DIFF_W - SAMPLE_W){v[SAMPLE_W-1]}}, v};
  endfunction

  // A gain register above one acts as exactly one.
  function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
    clamp_gain = g[GAIN_W-1] ? GAIN_ONE : g;
  endfunction

  assign smp_in[0] = in_data_i.sample_x;
  assign smp_in[1] = in_data_i.sample_y;
  assign smp_in[2] = in_data_i.sample_z;

  for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_res
    if (i < CHANNELS) begin : g_used
      assign res_all[i] = s_q[i];
    end else begin : g_unused
      assign res_all[i] = '0;
    end
  end

  assign ch     = cmd_i.ch[CH_W-1:0];
  assign x_cur  = smp_q[ch];
  assign lv_cur = level_q[ch];
  assign tr_cur = trend_q[ch];
  assign s_cur  = s_q[ch];
  assign lt_sum = sext(lv_cur) + sext(tr_cur);

  // Each blend g*a + (1-g)*b is formed as g*(a-b) + b*2^16.
  always_comb begin
    if (cmd_i.op == OP_MUL_B) begin
      gain_raw = clamp_gain(gamma_q);
      diff     = sext(s_cur) - sext(lv_cur) - sext(tr_cur);
    end else begin
      gain_raw = clamp_gain(alpha_q);
      diff     = sext(x_cur) - lt_sum;
    end
    base = (cmd_i.op == OP_ACC_B) ? sext(tr_cur) : lt_sum;
  end

  assign gain_s  = $signed({1'b0, gain_raw});
  assign mul_res = gain_s * diff;
  assign acc     = prod_q + ({{(ACC_W - DIFF_W){base[DIFF_W-1]}}, base} <<< 16)
                 + ACC_W'(32768);

  // The result is acc shifted right by 16 with floor, then clipped to 32 bits.
  always_comb begin
    if (&acc[ACC_W-1:SAMPLE_W+15] || ~|acc[ACC_W-1:SAMPLE_W+15]) begin
      sat_res = acc[SAMPLE_W+15:16];
    end else if (acc[ACC_W-1]) begin
      sat_res = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sat_res = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= GAIN_RESET;
      gamma_q <= GAIN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ALPHA: alpha_q <= cfg_wdata_i;
        CFG_GAMMA: gamma_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CHANNELS; i++) begin
      if (cmd_i.load_in) begin
        smp_q[i] <= smp_in[i];
      end
      if (cmd_i.prime) begin
        level_q[i] <= smp_q[i];
        trend_q[i] <= smp_q[i];
        s_q[i]     <= smp_q[i];
      end
    end
    case (cmd_i.op) inside
      OP_MUL_S, OP_MUL_B: prod_q <= mul_res;
      OP_ACC_S: s_q[ch] <= sat_res;
      OP_ACC_B: begin
        trend_q[ch] <= sat_res;
        level_q[ch] <= s_cur;
      end
      default: ;
    endcase
    if (cmd_i.load_out) begin
      out_q.smoothed_x <= res_all[0];
      out_q.smoothed_y <= res_all[1];
      out_q.smoothed_z <= res_all[2];
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

### rtl/des_ctrl.sv
// Controller of the smoother: sequences priming and the four steps per channel,
// and owns the input and output handshakes. Depends on des_pkg.
`default_nettype none

module des_ctrl #(
  parameter int unsigned CHANNELS = des_pkg::DEF_CHANNELS
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output des_pkg::dp_cmd_t cmd_o
);
  import des_pkg::*;

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_MUL_S,
    ST_ACC_S,
    ST_MUL_B,
    ST_ACC_B,
    ST_DONE
  } state_e;

  state_e          state_q;
  logic [CH_W-1:0] ch_q;
  logic            primed_q;
  logic            out_valid_q;
  logic            in_xfer;
  logic            load_out;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign load_out   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.load_in  = in_xfer;
    cmd_o.prime    = (state_q == ST_PRIME);
    cmd_o.ch       = CH_IDX_W'(ch_q);
    cmd_o.load_out = load_out;
    unique case (state_q)
      ST_MUL_S: cmd_o.op = OP_MUL_S;
      ST_ACC_S: cmd_o.op = OP_ACC_S;
      ST_MUL_B: cmd_o.op = OP_MUL_B;
      ST_ACC_B: cmd_o.op = OP_ACC_B;
      default:  cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          ch_q <= '0;
          if (in_xfer) begin
            state_q <= primed_q ? ST_MUL_S : ST_PRIME;
          end
        end
        ST_PRIME: begin
          primed_q <= 1'b1;
          state_q  <= ST_DONE;
        end
        ST_MUL_S: state_q <= ST_ACC_S;
        ST_ACC_S: state_q <= ST_MUL_B;
        ST_MUL_B: state_q <= ST_ACC_B;
        ST_ACC_B: begin
          if (ch_q == LAST_CH) begin
            state_q <= ST_DONE;
          end else begin
            ch_q    <= ch_q + CH_W'(1);
            state_q <= ST_MUL_S;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_ch_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_q <= LAST_CH)
    else $error("channel counter beyond the last channel");

  a_ch_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC_B && ch_q != LAST_CH)
      |=> (state_q == ST_MUL_S && ch_q == CH_W'($past(ch_q) + 1'b1)))
    else $error("channel sequence skipped or repeated a channel");

  a_prime_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PRIME) |=> (primed_q && state_q == ST_DONE))
    else $error("priming did not complete");

  a_primed_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && primed_q) |=> (state_q == ST_MUL_S && ch_q == '0))
    else $error("primed item did not start at the first channel");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result presented without a finished item");

endmodule

`default_nettype wire

### rtl/double_exponential_smoother_core.sv
// Top level of the double exponential smoother: controller, datapath and ports.
// Depends on des_pkg, des_in_if, des_out_if, des_ctrl and des_datapath.
//
// Holt double exponential smoother for up to three signed Q16.16 channels, with
// level gain alpha (register 0) and trend gain gamma (register 1), both unsigned
// Q1.16 where 65536 is one; larger values act as one. The first item after reset
// is passed through and loads level and trend with the sample in the priming
// state; its result register is loaded in the done state. Every later item runs
// through multiply and accumulate for the smoothed value, then for the trend, per
// channel in turn, then reaches the result register in the done state. This is
// set by the single shared 18x34 multiplier, used twice per channel, each product
// followed by one round-and-saturate step. Items are taken only in idle.
// A finished result waits in the output register while the next item is taken and
// worked on; a result still waiting when the next one is done adds its stall.
// Results saturate to the signed 32-bit range; unused channels read 0.
// Write the gain registers only while the block is idle.
`default_nettype none

module double_exponential_smoother_core #(
  parameter int unsigned CHANNELS = des_pkg::DEF_CHANNELS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  des_in_if.sink                              in_i,
  des_out_if.source                           out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [des_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [des_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import des_pkg::*;

  dp_cmd_t cmd;

  des_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  des_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_i.data),
    .out_data_o  (out_o.data),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench of the double exponential smoother core.
// Drives sample items and gain writes, predicts every smoothed item and checks it.
// Depends on des_pkg, des_in_if, des_out_if and double_exponential_smoother_core.
`timescale 1ns / 100ps

module testbench;
  import des_pkg::*;

  localparam int unsigned N_CH = DEF_CHANNELS;
  localparam int IDLE_PCT = 18;
  localparam int STALL_LIMIT = 1000;
  localparam int MAX_PRINTED = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7fffffff;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh80000000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  des_in_if in_if ();
  des_out_if out_if ();

  double_exponential_smoother_core #(
    .CHANNELS(N_CH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  logic [GAIN_W-1:0] alpha_reg;
  logic [GAIN_W-1:0] gamma_reg;
  logic signed [SAMPLE_W-1:0] level_st[MAX_CHANNELS];
  logic signed [SAMPLE_W-1:0] trend_st[MAX_CHANNELS];
  logic primed;

  out_item_t smoothed_q[$];
  int errors;
  int items_sent;
  int results_seen;
  int cfg_writes;
  int saturated_seen;
  bit no_idle;
  logic signed [SAMPLE_W-1:0] walk[MAX_CHANNELS];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= MAX_PRINTED) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
  endtask

  function automatic logic signed [SAMPLE_W-1:0] blend_q16(logic [GAIN_W-1:0] gain,
                                                           logic signed [32:0] a,
                                                           logic signed [32:0] b);
    logic signed [63:0] g;
    logic signed [63:0] acc;
    g = $signed({47'd0, gain});
    acc = g * a + (64'sd65536 - g) * b + 64'sd32768;
    acc = acc >>> 16;
    if (acc > 64'sd2147483647) begin
      saturated_seen++;
      return S_MAX;
    end else if (acc < -64'sd2147483648) begin
      saturated_seen++;
      return S_MIN;
    end
    return acc[SAMPLE_W-1:0];
  endfunction

  function automatic out_item_t smooth_item(in_item_t it);
    logic [GAIN_W-1:0] a_eff;
    logic [GAIN_W-1:0] g_eff;
    logic signed [SAMPLE_W-1:0] x[MAX_CHANNELS];
    logic signed [SAMPLE_W-1:0] s[MAX_CHANNELS];
    logic signed [32:0] sum;
    logic signed [32:0] diff;
    out_item_t res;
    a_eff = (alpha_reg > GAIN_ONE) ? GAIN_ONE : alpha_reg;
    g_eff = (gamma_reg > GAIN_ONE) ? GAIN_ONE : gamma_reg;
    x[0] = it.sample_x;
    x[1] = it.sample_y;
    x[2] = it.sample_z;
    for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
      if (ch >= N_CH) begin
        s[ch] = '0;
      end else if (!primed) begin
        level_st[ch] = x[ch];
        trend_st[ch] = x[ch];
        s[ch] = x[ch];
      end else begin
        sum = level_st[ch] + trend_st[ch];
        s[ch] = blend_q16(a_eff, x[ch], sum);
        diff = s[ch] - level_st[ch];
        trend_st[ch] = blend_q16(g_eff, diff, trend_st[ch]);
        level_st[ch] = s[ch];
      end
    end
    primed = 1'b1;
    res.smoothed_x = s[0];
    res.smoothed_y = s[1];
    res.smoothed_z = s[2];
    return res;
  endfunction

  task automatic send_item(in_item_t it);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk_i); while (!in_if.ready);
    smoothed_q.push_back(smooth_item(it));
    items_sent++;
  endtask

  task automatic send_xyz(logic signed [SAMPLE_W-1:0] x, logic signed [SAMPLE_W-1:0] y,
                          logic signed [SAMPLE_W-1:0] z);
    in_item_t it;
    it.sample_x = x;
    it.sample_y = y;
    it.sample_z = z;
    send_item(it);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (smoothed_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    if (idx == CFG_ALPHA) begin
      alpha_reg = value;
    end else if (idx == CFG_GAMMA) begin
      gamma_reg = value;
    end
    cfg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_gains(logic [GAIN_W-1:0] a, logic [GAIN_W-1:0] g);
    wait_drained();
    write_reg(CFG_ALPHA, a);
    write_reg(CFG_GAMMA, g);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(int ch);
    int mode;
    logic signed [SAMPLE_W-1:0] v;
    mode = $urandom_range(0, 99);
    if (mode < 60) begin
      walk[ch] = walk[ch] + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      v = walk[ch];
    end else if (mode < 85) begin
      v = $urandom;
    end else begin
      case ($urandom_range(0, 4))
        0: v = S_MAX;
        1: v = S_MIN;
        2: v = '0;
        3: v = -1;
        default: v = 1;
      endcase
    end
    return v;
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return GAIN_ONE;
      2: return GAIN_W'($urandom_range(65537, 131071));
      default: return GAIN_W'($urandom_range(1, 65535));
    endcase
  endfunction

  // The very first item must be the one after reset, so this test runs first.
  task automatic test_first_item();
    send_xyz(S_MAX, S_MIN, 32'sd0);
    send_xyz(S_MIN, S_MAX, -32'sd1);
    send_xyz(32'sd65536, -32'sd65536, 32'sd12345678);
  endtask

  task automatic test_spare_index();
    set_gains(GAIN_RESET, GAIN_RESET);
    write_reg(CFG_SPARE_2, 17'h1ffff);
    write_reg(CFG_SPARE_3, 17'h0);
    send_xyz(32'sd100000, -32'sd100000, 32'sd7);
    send_xyz(32'sd0, 32'sd0, 32'sd0);
  endtask

  task automatic test_gain_extremes();
    set_gains('0, '0);
    send_xyz(32'sd65536, -32'sd3, 32'sd1000);
    send_xyz(S_MAX, S_MIN, 32'sd1);
    send_xyz(-32'sd1, 32'sd1, 32'sd0);
    set_gains(GAIN_ONE, GAIN_ONE);
    send_xyz(S_MAX, S_MIN, -32'sd1);
    send_xyz(S_MIN, S_MAX, 32'sd1);
    send_xyz(32'sd123456, -32'sd654321, 32'sd0);
    set_gains(17'h1ffff, 17'h10001);
    send_xyz(32'sd5, S_MAX, S_MIN);
    send_xyz(-32'sd5, S_MIN, S_MAX);
    send_xyz(32'sd0, 32'sd0, 32'sd0);
  endtask

  // With full gains the output follows the sample; with no level gain it follows level plus trend.
  task automatic test_saturation();
    set_gains(GAIN_ONE, GAIN_ONE);
    send_xyz(S_MAX, S_MIN, S_MAX);
    send_xyz(S_MAX, S_MIN, S_MAX);
    set_gains('0, GAIN_ONE);
    send_xyz(S_MAX, S_MIN, 32'sd0);
    send_xyz(S_MIN, S_MAX, 32'sd0);
  endtask

  task automatic test_random(int phases, int per_phase);
    in_item_t it;
    for (int p = 0; p < phases; p++) begin
      set_gains(pick_gain(), pick_gain());
      no_idle = (p == 4);
      for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
        walk[ch] = $urandom;
      end
      for (int n = 0; n < per_phase; n++) begin
        it.sample_x = pick_sample(0);
        it.sample_y = pick_sample(1);
        it.sample_z = pick_sample(2);
        send_item(it);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    out_item_t got;
    out_item_t want;
    logic signed [SAMPLE_W-1:0] gv[3];
    logic signed [SAMPLE_W-1:0] wv[3];
    string names[3];
    names = '{"smoothed_x", "smoothed_y", "smoothed_z"};
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        results_seen++;
        if (smoothed_q.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = smoothed_q.pop_front();
          gv = '{got.smoothed_x, got.smoothed_y, got.smoothed_z};
          wv = '{want.smoothed_x, want.smoothed_y, want.smoothed_z};
          for (int i = 0; i < 3; i++) begin
            if (gv[i] !== wv[i]) begin
              report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                        results_seen, names[i], gv[i], wv[i]));
            end
          end
        end
      end
    end
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    alpha_reg = GAIN_RESET;
    gamma_reg = GAIN_RESET;
    primed = 1'b0;
    for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
      level_st[ch] = '0;
      trend_st[ch] = '0;
      walk[ch] = '0;
    end
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    cfg_writes = 0;
    saturated_seen = 0;
    no_idle = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_first_item();
    test_spare_index();
    test_gain_extremes();
    test_saturation();
    test_random(13, 100);

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d items and %0d results over %0d register writes,",
             items_sent, results_seen, cfg_writes);
    $display("with gain extremes, spare indexes and %0d saturated blends.", saturated_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
rtl/des_pkg.sv
rtl/des_in_if.sv
rtl/des_out_if.sv
rtl/des_datapath.sv
rtl/des_ctrl.sv
rtl/double_exponential_smoother_core.sv
tb/testbench.sv
